### hdl/char_class_tokenizer_assert.svh
// Assertion macros for the tokenizer. Each macro samples on the rising edge of clock.
`ifndef CHAR_CLASS_TOKENIZER_ASSERT_SVH
`define CHAR_CLASS_TOKENIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CCT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CCT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CCT_ASSERT(lbl, prop, msg)
`define CCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hdl/cct_pkg.sv
`default_nettype none
package cct_pkg;

   localparam int CHAR_W    = 8;
   localparam int SET_W     = 64;
   localparam int SET_CHARS = 8;
   localparam int SLOT_W    = (SET_CHARS > 1) ? $clog2(SET_CHARS) : 1;
   localparam int EV_W      = 3;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [EV_W-1:0] EV_CHAR   = 3'd0;
   localparam logic [EV_W-1:0] EV_UEND   = 3'd1;
   localparam logic [EV_W-1:0] EV_QEND   = 3'd2;
   localparam logic [EV_W-1:0] EV_SINGLE = 3'd3;
   localparam logic [EV_W-1:0] EV_EOF    = 3'd4;
   localparam logic [EV_W-1:0] EV_ERROR  = 3'd5;

   localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UNQ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUO  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SKIP = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SPACE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMENT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_Q  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_Q = 3'd4;

   localparam logic [SET_W-1:0] SPACE_RESET   = 64'h0000_0000_0A0D_0920;
   localparam logic [SET_W-1:0] COMMENT_RESET = 64'h0000_0000_0000_0023;
   localparam logic [SET_W-1:0] SINGLE_RESET  = 64'h0000_0000_0000_0000;
   localparam logic [SET_W-1:0] OPEN_Q_RESET  = 64'h0000_0000_0000_0022;
   localparam logic [SET_W-1:0] CLOSE_Q_RESET = 64'h0000_0000_0000_0022;

   typedef struct packed {
      logic [SET_W-1:0] space;
      logic [SET_W-1:0] comment;
      logic [SET_W-1:0] single_tok;
      logic [SET_W-1:0] open_q;
      logic [SET_W-1:0] close_q;
   } sets_type;

   typedef struct packed {
      logic [EV_W-1:0]   event_res;
      logic [CHAR_W-1:0] char_out;
      logic              last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } slot_hit_type;

   // Lowest matching slot wins; a zero byte never matches.
   function automatic slot_hit_type find_slot(input logic [SET_W-1:0] set,
                                              input logic [CHAR_W-1:0] c);
      slot_hit_type r;
      r = '0;
      for (int i = SET_CHARS - 1; i >= 0; i--) begin
         if (c != '0 && set[CHAR_W*i +: CHAR_W] == c) begin
            r.hit  = 1'b1;
            r.slot = SLOT_W'(i);
         end
      end
      return r;
   endfunction

   function automatic result_type make_result(input logic [EV_W-1:0] ev,
                                              input logic [CHAR_W-1:0] c);
      result_type r;
      r.event_res = ev;
      r.char_out  = (ev == EV_CHAR || ev == EV_SINGLE) ? c : '0;
      r.last      = 1'b0;
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/cct_classify.sv
`default_nettype none
`include "char_class_tokenizer_assert.svh"
module cct_classify (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [cct_pkg::CHAR_W-1:0] byte_in,
   input  wire logic                      fire,
   input  wire cct_pkg::sets_type         sets,
   output cct_pkg::step_type              step
);
   import cct_pkg::*;

   logic [MODE_W-1:0] mode_ff, mode_in, next_mode;
   logic [CHAR_W-1:0] close_ff, close_in;

   slot_hit_type hit_space, hit_comment, hit_single, hit_open;

   logic              idle_has;
   result_type        idle_res;
   logic [MODE_W-1:0] idle_mode;
   logic              idle_load;
   logic              ends_unq;
   logic              load_close;
   step_type          raw;

   always_comb begin
      hit_space   = find_slot(sets.space, byte_in);
      hit_comment = find_slot(sets.comment, byte_in);
      hit_single  = find_slot(sets.single_tok, byte_in);
      hit_open    = find_slot(sets.open_q, byte_in);
      ends_unq    = byte_in == '0 || hit_space.hit || hit_comment.hit || hit_single.hit;
   end

   // Handling of a byte that arrives between tokens.
   always_comb begin
      idle_has  = 1'b0;
      idle_res  = make_result(EV_EOF, byte_in);
      idle_mode = MODE_IDLE;
      idle_load = 1'b0;
      if (byte_in == '0) begin
         idle_has = 1'b1;
      end else if (hit_space.hit) begin
         idle_has = 1'b0;
      end else if (hit_comment.hit) begin
         idle_has  = 1'b1;
         idle_mode = MODE_SKIP;
      end else if (hit_single.hit) begin
         idle_has = 1'b1;
         idle_res = make_result(EV_SINGLE, byte_in);
      end else if (hit_open.hit) begin
         idle_mode = MODE_QUO;
         idle_load = 1'b1;
      end else begin
         idle_has  = 1'b1;
         idle_res  = make_result(EV_CHAR, byte_in);
         idle_mode = MODE_UNQ;
      end
   end

   always_comb begin
      raw        = '0;
      next_mode  = mode_ff;
      load_close = 1'b0;
      unique case (mode_ff)
         MODE_IDLE: begin
            raw.count  = {1'b0, idle_has};
            raw.first  = idle_res;
            next_mode  = idle_mode;
            load_close = idle_load;
         end
         MODE_UNQ: begin
            if (ends_unq) begin
               raw.count  = idle_has ? 2'd2 : 2'd1;
               raw.first  = make_result(EV_UEND, byte_in);
               raw.second = idle_res;
               next_mode  = idle_mode;
               load_close = idle_load;
            end else begin
               raw.count = 2'd1;
               raw.first = make_result(EV_CHAR, byte_in);
            end
         end
         MODE_QUO: begin
            raw.count = 2'd1;
            if (byte_in == '0) begin
               raw.first = make_result(EV_ERROR, byte_in);
               next_mode = MODE_IDLE;
            end else if (byte_in == close_ff) begin
               raw.first = make_result(EV_QEND, byte_in);
               next_mode = MODE_IDLE;
            end else begin
               raw.first = make_result(EV_CHAR, byte_in);
            end
         end
         MODE_SKIP: begin
            if (byte_in == '0) begin
               next_mode = MODE_IDLE;
            end
         end
         default: begin
            next_mode = MODE_IDLE;
         end
      endcase
   end

   always_comb begin
      step             = raw;
      step.first.last  = raw.count == 2'd1;
      step.second.last = raw.count == 2'd2;
      mode_in          = fire ? next_mode : mode_ff;
      close_in         = (fire && load_close) ? sets.close_q[CHAR_W*hit_open.slot +: CHAR_W]
                                              : close_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         close_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         close_ff <= close_in;
      end
   end

   `CCT_ASSERT(a_quote_zero_error, ((fire && mode_ff == MODE_QUO && byte_in == '0) |=> (mode_ff == MODE_IDLE)), "Zero byte inside a quote did not return to between tokens")
   `CCT_ASSERT(a_skip_silent, ((mode_ff == MODE_SKIP) |-> (step.count == 2'd0)), "Byte after a comment produced a result")
   `CCT_ASSERT(a_pair_starts_uend, ((step.count == 2'd2) |-> (mode_ff == MODE_UNQ && step.first.event_res == EV_UEND)), "Two results without an unquoted string end")

endmodule
`default_nettype wire

### hdl/cct_rsp_buf.sv
`default_nettype none
`include "char_class_tokenizer_assert.svh"
module cct_rsp_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cct_pkg::step_type step,
   output logic                   can_load,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output cct_pkg::result_type    out_res
);
   import cct_pkg::*;

   logic [1:0] cnt_ff, cnt_in;
   result_type head_ff, head_in;
   result_type tail_ff, tail_in;
   logic       pop;

   always_comb begin
      pop      = cnt_ff != 2'd0 && out_ready;
      can_load = cnt_ff == 2'd0 || (cnt_ff == 2'd1 && out_ready);
      cnt_in   = pop ? cnt_ff - 2'd1 : cnt_ff;
      head_in  = pop ? tail_ff : head_ff;
      tail_in  = tail_ff;
      if (push && step.count != 2'd0) begin
         cnt_in  = step.count;
         head_in = step.first;
         tail_in = step.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign out_valid = cnt_ff != 2'd0;
   assign out_res   = head_ff;

   `CCT_ASSERT(a_cnt_range, (cnt_ff != 2'd3), "Result buffer count out of range")
   `CCT_ASSERT(a_push_room, ((push && step.count != 2'd0) |-> can_load), "Results loaded into a buffer without room")
   `CCT_ASSERT(a_push_count, ((push && step.count != 2'd0) |=> (cnt_ff == $past(step.count))), "Result buffer count does not match the loaded item")

endmodule
`default_nettype wire

### hdl/char_class_tokenizer.sv
// Path: a byte is registered on acceptance and classified, and its results are loaded into
// the two-entry result buffer. Throughput: one byte per cycle while the output is ready; a
// result byte after one that closes an unquoted string with a second result waits for room.
// Reset: synchronous, active high; restores the default character sets and the between-tokens
// mode and empties the input register and the result buffer.
`default_nettype none
module char_class_tokenizer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [7:0]                   req_tdata,  // byte_in[7:0]
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [15:0]                       rsp_tdata,  // event_res[2:0], char_out[10:3], zero
   output logic                              rsp_tlast,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [cct_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cct_pkg::SET_W-1:0]     csr_data
);
   import cct_pkg::*;

   sets_type          sets_ff, sets_in;
   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] byte_ff, byte_in;
   logic              in_fire;
   logic              can_load;
   step_type          step;
   result_type        out_res;

   assign csr_ready = 1'b1;

   always_comb begin
      sets_in = sets_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SPACE:   sets_in.space      = csr_data;
            CSR_COMMENT: sets_in.comment    = csr_data;
            CSR_SINGLE:  sets_in.single_tok = csr_data;
            CSR_OPEN_Q:  sets_in.open_q     = csr_data;
            CSR_CLOSE_Q: sets_in.close_q    = csr_data;
            default:     sets_in            = sets_ff;
         endcase
      end
   end

   always_comb begin
      in_fire     = in_valid_ff && (step.count == 2'd0 || can_load);
      req_tready  = !in_valid_ff || in_fire;
      in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (in_fire ? 1'b0 : in_valid_ff);
      byte_in     = (req_tvalid && req_tready) ? req_tdata : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sets_ff.space      <= SPACE_RESET;
         sets_ff.comment    <= COMMENT_RESET;
         sets_ff.single_tok <= SINGLE_RESET;
         sets_ff.open_q     <= OPEN_Q_RESET;
         sets_ff.close_q    <= CLOSE_Q_RESET;
         in_valid_ff        <= 1'b0;
      end else begin
         sets_ff     <= sets_in;
         in_valid_ff <= in_valid_in;
      end
      byte_ff <= byte_in;
   end

   cct_classify u_classify (
      .clock   (clock),
      .reset   (reset),
      .byte_in (byte_ff),
      .fire    (in_fire),
      .sets    (sets_ff),
      .step    (step)
   );

   cct_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (in_fire),
      .step      (step),
      .can_load  (can_load),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = {5'b0, out_res.char_out, out_res.event_res};
   assign rsp_tlast = out_res.last;

endmodule
`default_nettype wire

### tb/tb_char_class_tokenizer.sv
`default_nettype none
module tb_char_class_tokenizer;
   import cct_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;  // byte_in[7:0]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;       // event_res[2:0], char_out[10:3], zero
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SET_W-1:0]     csr_data = '0;

   char_class_tokenizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Tokenizer state as predicted from the accepted bytes and register writes.
   logic [SET_W-1:0]  set_space   = SPACE_RESET;
   logic [SET_W-1:0]  set_comment = COMMENT_RESET;
   logic [SET_W-1:0]  set_single  = SINGLE_RESET;
   logic [SET_W-1:0]  set_open    = OPEN_Q_RESET;
   logic [SET_W-1:0]  set_close   = CLOSE_Q_RESET;
   logic [MODE_W-1:0] tok_mode    = MODE_IDLE;
   logic [7:0]        tok_close   = '0;

   result_type pending_tokens [$];
   result_type step_tokens [$];

   int mismatches      = 0;
   int cycles          = 0;
   int sent_bytes      = 0;
   int tx_max_gap      = 0;
   int rx_max_gap      = 0;
   int rx_wait         = 0;
   int hold_off_cycles = 0;

   function automatic int class_slot(input logic [SET_W-1:0] set, input logic [7:0] c);
      int hit;
      hit = -1;
      if (c != 8'h00) begin
         for (int i = SET_CHARS - 1; i >= 0; i--) begin
            if (set[8*i +: 8] == c) hit = i;
         end
      end
      return hit;
   endfunction

   task automatic add_token(input logic [EV_W-1:0] ev, input logic [7:0] c);
      result_type r;
      r.event_res = ev;
      r.char_out  = (ev == EV_CHAR || ev == EV_SINGLE) ? c : 8'h00;
      r.last      = 1'b0;
      step_tokens.push_back(r);
   endtask

   task automatic between_tokens(input logic [7:0] c);
      int s;
      s = class_slot(set_open, c);
      if (c == 8'h00) begin
         add_token(EV_EOF, c);
         tok_mode = MODE_IDLE;
      end else if (class_slot(set_space, c) >= 0) begin
         tok_mode = MODE_IDLE;
      end else if (class_slot(set_comment, c) >= 0) begin
         add_token(EV_EOF, c);
         tok_mode = MODE_SKIP;
      end else if (class_slot(set_single, c) >= 0) begin
         add_token(EV_SINGLE, c);
         tok_mode = MODE_IDLE;
      end else if (s >= 0) begin
         tok_close = set_close[8*s +: 8];
         tok_mode  = MODE_QUO;
      end else begin
         add_token(EV_CHAR, c);
         tok_mode = MODE_UNQ;
      end
   endtask

   task automatic predict_byte(input logic [7:0] c);
      step_tokens.delete();
      case (tok_mode)
         MODE_IDLE: begin
            between_tokens(c);
         end
         MODE_UNQ: begin
            if (c == 8'h00 || class_slot(set_space, c) >= 0 || class_slot(set_comment, c) >= 0
                || class_slot(set_single, c) >= 0) begin
               add_token(EV_UEND, c);
               between_tokens(c);
            end else begin
               add_token(EV_CHAR, c);
            end
         end
         MODE_QUO: begin
            if (c == 8'h00) begin
               add_token(EV_ERROR, c);
               tok_mode = MODE_IDLE;
            end else if (c == tok_close) begin
               add_token(EV_QEND, c);
               tok_mode = MODE_IDLE;
            end else begin
               add_token(EV_CHAR, c);
            end
         end
         default: begin
            if (c == 8'h00) tok_mode = MODE_IDLE;
         end
      endcase
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
      foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("char_class_tokenizer regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) rx_wait = $urandom_range(0, rx_max_gap);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_tready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tokens.size() == 0) begin
            $error("unexpected result: event_res %0d char_out %0h last %0b",
                   rsp_tdata[2:0], rsp_tdata[10:3], rsp_tlast);
            mismatches++;
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_tdata[2:0] !== want.event_res) begin
               $error("event_res: expected %0d, actual %0d", want.event_res, rsp_tdata[2:0]);
               mismatches++;
            end
            if (rsp_tdata[10:3] !== want.char_out) begin
               $error("char_out: expected %0h, actual %0h", want.char_out, rsp_tdata[10:3]);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, tx_max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predict_byte(b);
      sent_bytes++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SET_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SPACE:   set_space   = data;
         CSR_COMMENT: set_comment = data;
         CSR_SINGLE:  set_single  = data;
         CSR_OPEN_Q:  set_open    = data;
         CSR_CLOSE_Q: set_close   = data;
         default: ;
      endcase
   endtask

   task automatic load_sets(input logic [SET_W-1:0] sp, input logic [SET_W-1:0] cm,
                            input logic [SET_W-1:0] sg, input logic [SET_W-1:0] op,
                            input logic [SET_W-1:0] cl);
      write_csr(CSR_SPACE, sp);
      write_csr(CSR_COMMENT, cm);
      write_csr(CSR_SINGLE, sg);
      write_csr(CSR_OPEN_Q, op);
      write_csr(CSR_CLOSE_Q, cl);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0 && n < 5000) begin
         @(posedge clock);
         n++;
      end
      repeat (6) @(posedge clock);
      if (pending_tokens.size() != 0) begin
         $error("%0d expected results never arrived", pending_tokens.size());
         mismatches++;
         pending_tokens.delete();
      end
   endtask

   function automatic logic [7:0] member_of(input logic [SET_W-1:0] set);
      logic [7:0] found [$];
      for (int i = 0; i < SET_CHARS; i++) begin
         if (set[8*i +: 8] != 8'h00) found.push_back(set[8*i +: 8]);
      end
      if (found.size() == 0) return 8'h00;
      return found[$urandom_range(0, found.size() - 1)];
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'h61;
      for (int tries = 0; tries < 64; tries++) begin
         b = 8'($urandom_range(1, 255));
         if (class_slot(set_space, b) < 0 && class_slot(set_comment, b) < 0
             && class_slot(set_single, b) < 0 && class_slot(set_open, b) < 0
             && class_slot(set_close, b) < 0) return b;
      end
      return b;
   endfunction

   function automatic logic [SET_W-1:0] random_set();
      logic [SET_W-1:0] s;
      s = '0;
      for (int i = 0; i < SET_CHARS; i++) begin
         if ($urandom_range(0, 3) != 0) s[8*i +: 8] = 8'($urandom_range(1, 255));
      end
      return s;
   endfunction

   task automatic send_phrase();
      int kind;
      int n;
      logic [7:0] b;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         n = $urandom_range(1, 6);
         repeat (n) push_byte(plain_byte());
         case ($urandom_range(0, 3))
            0: b = member_of(set_space);
            1: b = member_of(set_single);
            2: b = member_of(set_comment);
            default: b = 8'h00;
         endcase
         push_byte(b);
      end else if (kind < 50) begin
         b = member_of(set_open);
         push_byte(b == 8'h00 ? plain_byte() : b);
         if (tok_mode == MODE_QUO) begin
            n = $urandom_range(0, 6);
            repeat (n) begin
               b = 8'($urandom_range(1, 255));
               if (b == tok_close) b = plain_byte();
               push_byte(b);
            end
            if (tok_close != 8'h00 && $urandom_range(0, 7) != 0) push_byte(tok_close);
            else push_byte(8'h00);
         end
      end else if (kind < 62) begin
         b = member_of(set_single);
         push_byte(b == 8'h00 ? plain_byte() : b);
      end else if (kind < 72) begin
         n = $urandom_range(1, 3);
         repeat (n) push_byte(member_of(set_space));
      end else if (kind < 80) begin
         b = member_of(set_comment);
         push_byte(b == 8'h00 ? 8'($urandom_range(0, 255)) : b);
      end else if (kind < 85) begin
         push_byte(8'h00);
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) push_byte(8'($urandom_range(0, 255)));
      end
      if (tok_mode == MODE_SKIP) begin
         n = $urandom_range(0, 5);
         repeat (n) push_byte(8'($urandom_range(1, 255)));
         push_byte(8'h00);
      end
   endtask

   task automatic random_traffic(input int items, input int tx_gap, input int rx_gap);
      int stop_at;
      stop_at    = sent_bytes + items;
      tx_max_gap = tx_gap;
      rx_max_gap = rx_gap;
      while (sent_bytes < stop_at) send_phrase();
      wait_idle();
   endtask

   task automatic test_reset_sets();
      logic [7:0] seq [$];
      seq = '{8'h00, " ", "a", 8'hFF, "#", "x", 8'h00, 8'h22, 8'h01, " ", 8'h22, 8'h22, 8'h00};
      tx_max_gap = 3;
      rx_max_gap = 3;
      foreach (seq[i]) push_byte(seq[i]);
      wait_idle();
   endtask

   task automatic test_class_priority();
      logic [7:0] seq [$];
      // Space and comment outrank single tokens, which outrank quotes; "[" has no closer.
      load_sets(SPACE_RESET, COMMENT_RESET, 64'h0000_0000_0023_2028,
                64'h0000_0000_2028_3C5B, 64'h0000_0000_0029_3E00);
      seq = '{"b", "(", "[", "z", "]", 8'h00, "<", ">", "k", " ", "m", 8'h00};
      foreach (seq[i]) push_byte(seq[i]);
      wait_idle();
   endtask

   task automatic test_default_sets();
      load_sets(SPACE_RESET, COMMENT_RESET, SINGLE_RESET, OPEN_Q_RESET, CLOSE_Q_RESET);
      random_traffic(250, 0, 0);
   endtask

   task automatic test_rich_sets();
      load_sets(64'h0000_002C_0A0D_0920, 64'h0000_0000_0000_3B23,
                64'h2B3D_7D7B_5D5B_2928, 64'h0000_0000_6027_3C22,
                64'h0000_0000_2700_3E22);
      random_traffic(250, 17, 17);
   endtask

   task automatic test_random_sets();
      repeat (2) begin
         load_sets(random_set(), random_set(), random_set(), random_set(), random_set());
         random_traffic(250, $urandom_range(0, 17), $urandom_range(0, 17));
      end
   endtask

   task automatic test_empty_sets();
      load_sets('0, '0, '0, '0, '0);
      random_traffic(250, 17, 0);
   endtask

   task automatic test_full_sets();
      load_sets('1, '1, '1, '1, '1);
      random_traffic(125, 0, 17);
      // A quote whose close slot is empty can only end in an error.
      load_sets('1, 64'h0000_0000_0000_0023, '0, 64'h0000_0000_0000_2722,
                64'h0000_0000_0000_2700);
      random_traffic(125, 5, 5);
   endtask

   task automatic test_backpressure();
      load_sets(64'h0000_0000_0A0D_0920, 64'h0000_0000_0000_0023,
                64'h0000_0000_0029_2800, 64'h0000_0000_0000_2722,
                64'h0000_0000_0000_2722);
      tx_max_gap = 0;
      rx_max_gap = 0;
      hold_off_cycles = 400;
      random_traffic(250, 0, 0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_sets();
      test_class_priority();
      test_default_sets();
      test_rich_sets();
      test_random_sets();
      test_empty_sets();
      test_full_sets();
      test_backpressure();
      wait_idle();
      if (mismatches == 0) begin
         $display("char_class_tokenizer regression: pass");
      end else begin
         $display("char_class_tokenizer regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
